// ===== sv/usb_transfer_descriptor_splitter_core_macros.svh =====
// Assertion macros shared by the descriptor splitter RTL.
`ifndef USB_TRANSFER_DESCRIPTOR_SPLITTER_CORE_MACROS_SVH
`define USB_TRANSFER_DESCRIPTOR_SPLITTER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, sampled on clk, idle in reset.
`define USB_TDS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("usb_tds implication check failed");
// Next-cycle implication.
`define USB_TDS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("usb_tds next-cycle check failed");
`else
`define USB_TDS_ASSERT_IMP(label, ante, cons)
`define USB_TDS_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ===== sv/usb_tds_pkg.sv =====
// Shared types and constants for the transfer descriptor splitter.
package usb_tds_pkg;

    localparam int MAX_DESCRIPTORS_DEF = 18;
    localparam int PAGE_BYTES_DEF      = 4096;
    localparam int QUEUE_DEPTH_DEF     = 2;
    localparam int SETUP_BYTES         = 8;

    localparam int ADDR_W = 32;
    localparam int SIZE_W = 18;
    localparam int MPL_W  = 4;
    localparam int IDX_W  = 5;
    localparam int PID_W  = 2;
    localparam int TOG_W  = 2;
    localparam int IN_USER_W   = 2;
    localparam int OUT_USER_W  = 3;
    localparam int IN_TDATA_W  = ((2 * ADDR_W + SIZE_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((IDX_W + PID_W + TOG_W + 2 * ADDR_W + 7) / 8) * 8;

    localparam logic [MPL_W-1:0] MPL_RESET = 4'd6;

    // token kinds
    localparam logic [PID_W-1:0] PID_SETUP = 2'd0;
    localparam logic [PID_W-1:0] PID_OUT   = 2'd1;
    localparam logic [PID_W-1:0] PID_IN    = 2'd2;

    // toggle modes
    localparam logic [TOG_W-1:0] TOG_CARRY = 2'd0;
    localparam logic [TOG_W-1:0] TOG_DATA0 = 2'd1;
    localparam logic [TOG_W-1:0] TOG_DATA1 = 2'd2;

    // first stage of a request, decided at the front
    typedef enum logic [2:0] {
        CLS_SETUP = 3'b001,
        CLS_DATA  = 3'b010,
        CLS_EMPTY = 3'b100
    } req_class_t;

    typedef struct packed {
        logic              is_in;
        logic              has_setup;
        logic [ADDR_W-1:0] setup_addr;
        logic [ADDR_W-1:0] data_addr;
        logic [SIZE_W-1:0] data_size;
        req_class_t        cls;
    } req_t;

    typedef struct packed {
        logic              td_valid;
        logic [IDX_W-1:0]  td_index;
        logic [PID_W-1:0]  pid_kind;
        logic [TOG_W-1:0]  toggle_mode;
        logic [ADDR_W-1:0] buffer_start;
        logic [ADDR_W-1:0] buffer_end;
        logic              status;
        logic              kick_control_list;
        logic              last;
    } td_t;

endpackage

// ===== sv/usb_tds_front.sv =====
// Request intake: unpacks the input transaction and classifies its first stage.
module usb_tds_front
    import usb_tds_pkg::*;
(
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,
    input  logic [IN_USER_W-1:0]  s_tuser,
    output logic                  push,
    output req_t                  push_req,
    input  logic                  q_full
);

    logic [SIZE_W-1:0] size;

    assign size     = s_tdata[2*ADDR_W +: SIZE_W];
    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    always_comb
    begin
        push_req.is_in      = s_tuser[0];
        push_req.has_setup  = s_tuser[1];
        push_req.setup_addr = s_tdata[0 +: ADDR_W];
        push_req.data_addr  = s_tdata[ADDR_W +: ADDR_W];
        push_req.data_size  = size;
        if (s_tuser[1])
        begin
            push_req.cls = CLS_SETUP;
        end
        else if (size != '0)
        begin
            push_req.cls = CLS_DATA;
        end
        else
        begin
            push_req.cls = CLS_EMPTY;
        end
    end

endmodule

// ===== sv/usb_tds_queue.sv =====
// Short request queue between intake and descriptor sequencer.
module usb_tds_queue
    import usb_tds_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  req_t push_req,
    output logic full,
    input  logic pop,
    output req_t pop_req,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    req_t             mem [DEPTH];
    req_t             head_reg;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_req = head_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    always_comb
    begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // head entry is read ahead; a write into the next head slot goes straight through
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_req;
        end
        if (do_push && (wr_ptr_reg == rd_ptr_next))
        begin
            head_reg <= push_req;
        end
        else
        begin
            head_reg <= mem[rd_ptr_next];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== sv/usb_tds_back.sv =====
// Sequencer: walks setup, data pieces, status; one descriptor a cycle unless stalled.
module usb_tds_back
    import usb_tds_pkg::*;
#(
    parameter int MAX_DESCRIPTORS = MAX_DESCRIPTORS_DEF,
    parameter int PAGE_BYTES      = PAGE_BYTES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [MPL_W-1:0] max_packet_log2,
    input  req_t             q_req,
    input  logic             q_empty,
    output logic             q_pop,
    output logic             out_valid,
    output td_t              out_td,
    input  logic             out_ready
);

    localparam int KW        = $clog2(MAX_DESCRIPTORS + 1);
    localparam int PAGE_LOG2 = $clog2(PAGE_BYTES);
    localparam int WIN_W     = PAGE_LOG2 + 2;
    localparam int CMP_W     = (SIZE_W > WIN_W) ? SIZE_W : WIN_W;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SETUP  = 5'b00010,
        ST_DATA   = 5'b00100,
        ST_STATUS = 5'b01000,
        ST_EMPTY  = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [KW-1:0]     k_reg, k_next;
    logic [ADDR_W-1:0] dest_reg, dest_next;
    logic [SIZE_W-1:0] remain_reg, remain_next;
    logic [ADDR_W-1:0] setup_addr_reg, setup_addr_next;
    logic              is_in_reg, is_in_next;
    logic              has_setup_reg, has_setup_next;
    logic              out_valid_reg, out_valid_next;
    td_t               out_reg, out_next;

    logic              emit_ok;
    logic              k_full;
    logic [CMP_W-1:0]  window;
    logic [CMP_W-1:0]  mp_mask;
    logic [CMP_W-1:0]  remain_ext;
    logic [CMP_W-1:0]  piece;
    logic [CMP_W-1:0]  remain_left;
    logic              shorten;
    logic              emit;
    td_t               item;
    td_t               err_item;

    assign emit_ok    = !out_valid_reg || out_ready;
    assign k_full     = (k_reg >= KW'(MAX_DESCRIPTORS));

    // window reaches to the end of the page after the current one
    assign window     = CMP_W'(2 * PAGE_BYTES) - CMP_W'(dest_reg[PAGE_LOG2-1:0]);
    assign mp_mask    = CMP_W'((32'd1 << max_packet_log2) - 32'd1);
    assign remain_ext = CMP_W'(remain_reg);
    assign shorten    = (remain_ext > window);
    assign piece      = shorten ? (window & ~mp_mask) : remain_ext;
    assign remain_left = remain_ext - piece;

    always_comb
    begin
        err_item        = '0;
        err_item.status = 1'b1;
        err_item.last   = 1'b1;
    end

    always_comb
    begin
        state_next      = state_reg;
        k_next          = k_reg;
        dest_next       = dest_reg;
        remain_next     = remain_reg;
        setup_addr_next = setup_addr_reg;
        is_in_next      = is_in_reg;
        has_setup_next  = has_setup_reg;
        q_pop           = 1'b0;
        emit            = 1'b0;
        item            = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop           = 1'b1;
                    k_next          = '0;
                    dest_next       = q_req.data_addr;
                    remain_next     = q_req.data_size;
                    setup_addr_next = q_req.setup_addr;
                    is_in_next      = q_req.is_in;
                    has_setup_next  = q_req.has_setup;
                    case (q_req.cls)
                        CLS_SETUP: state_next = ST_SETUP;
                        CLS_DATA:  state_next = ST_DATA;
                        default:   state_next = ST_EMPTY;
                    endcase
                end
            end
            ST_SETUP:
            begin
                if (emit_ok)
                begin
                    emit                   = 1'b1;
                    item.td_valid          = 1'b1;
                    item.td_index          = IDX_W'(k_reg);
                    item.pid_kind          = PID_SETUP;
                    item.toggle_mode       = TOG_DATA0;
                    item.buffer_start      = setup_addr_reg;
                    item.buffer_end        = setup_addr_reg + ADDR_W'(SETUP_BYTES - 1);
                    item.kick_control_list = 1'b1;
                    k_next                 = k_reg + KW'(1);
                    state_next             = (remain_reg != '0) ? ST_DATA : ST_STATUS;
                end
            end
            ST_DATA:
            begin
                if (emit_ok)
                begin
                    emit = 1'b1;
                    // packet larger than the window also ends the run in error
                    if (k_full || (shorten && piece == '0))
                    begin
                        item       = err_item;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        item.td_valid          = 1'b1;
                        item.td_index          = IDX_W'(k_reg);
                        item.pid_kind          = is_in_reg ? PID_IN : PID_OUT;
                        item.toggle_mode       = has_setup_reg ? TOG_DATA1 : TOG_CARRY;
                        item.buffer_start      = dest_reg;
                        item.buffer_end        = dest_reg + ADDR_W'(piece) - ADDR_W'(1);
                        item.kick_control_list = has_setup_reg;
                        k_next                 = k_reg + KW'(1);
                        dest_next              = dest_reg + ADDR_W'(piece);
                        remain_next            = SIZE_W'(remain_left);
                        if (remain_left == '0)
                        begin
                            if (has_setup_reg)
                            begin
                                state_next = ST_STATUS;
                            end
                            else
                            begin
                                item.last  = 1'b1;
                                state_next = ST_IDLE;
                            end
                        end
                    end
                end
            end
            ST_STATUS:
            begin
                if (emit_ok)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                    if (k_full)
                    begin
                        item = err_item;
                    end
                    else
                    begin
                        item.td_valid          = 1'b1;
                        item.td_index          = IDX_W'(k_reg);
                        item.pid_kind          = is_in_reg ? PID_OUT : PID_IN;
                        item.toggle_mode       = TOG_DATA1;
                        item.kick_control_list = 1'b1;
                        item.last              = 1'b1;
                    end
                end
            end
            ST_EMPTY:
            begin
                if (emit_ok)
                begin
                    emit       = 1'b1;
                    item.last  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_next       = item;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg          <= k_next;
        dest_reg       <= dest_next;
        remain_reg     <= remain_next;
        setup_addr_reg <= setup_addr_next;
        is_in_reg      <= is_in_next;
        has_setup_reg  <= has_setup_next;
        out_reg        <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_td    = out_reg;

endmodule

// ===== sv/usb_transfer_descriptor_splitter_core.sv =====
// Top level of the USB transfer descriptor splitter.
//
// Takes one transfer request per input transaction and returns its chain of
// transfer descriptors, one output transaction per descriptor, the last one
// flagged with m_tlast. The sequencer loads each request, then emits one
// descriptor per cycle while m_tready is high, using a single piece
// calculator. A request queue of QUEUE_DEPTH entries lets new requests be
// taken while a chain is still being emitted. Page size must be a power of
// two. max_packet_log2 is written through the cfg channel, which is always
// ready; write it only while no request is in flight.
`include "usb_transfer_descriptor_splitter_core_macros.svh"

module usb_transfer_descriptor_splitter_core
    import usb_tds_pkg::*;
#(
    parameter int MAX_DESCRIPTORS = MAX_DESCRIPTORS_DEF,
    parameter int PAGE_BYTES      = PAGE_BYTES_DEF,
    parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [MPL_W-1:0]       cfg_data,      // max_packet_log2
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // setup_addr[31:0], data_addr[63:32], data_size[81:64], zero pad
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic [IN_USER_W-1:0]   s_tuser,       // is_in[0], has_setup[1]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // td_index[4:0], pid_kind[6:5], toggle_mode[8:7], buffer_start[40:9],
    // buffer_end[72:41], zero pad
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic [OUT_USER_W-1:0]  m_tuser,       // td_valid[0], status[1], kick_control_list[2]
    output logic                   m_tlast
);

    logic [MPL_W-1:0] mpl_reg, mpl_next;
    logic             push, q_full, q_pop, q_empty;
    req_t             push_req, pop_req;
    td_t              td;

    assign cfg_ready = 1'b1;
    assign mpl_next  = cfg_valid ? cfg_data : mpl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mpl_reg <= MPL_RESET;
        end
        else
        begin
            mpl_reg <= mpl_next;
        end
    end

    usb_tds_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .push     (push),
        .push_req (push_req),
        .q_full   (q_full)
    );

    usb_tds_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_req (push_req),
        .full     (q_full),
        .pop      (q_pop),
        .pop_req  (pop_req),
        .empty    (q_empty)
    );

    usb_tds_back #(
        .MAX_DESCRIPTORS (MAX_DESCRIPTORS),
        .PAGE_BYTES      (PAGE_BYTES)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .max_packet_log2 (mpl_reg),
        .q_req           (pop_req),
        .q_empty         (q_empty),
        .q_pop           (q_pop),
        .out_valid       (m_tvalid),
        .out_td          (td),
        .out_ready       (m_tready)
    );

    assign m_tdata = OUT_TDATA_W'({td.buffer_end, td.buffer_start, td.toggle_mode,
                                   td.pid_kind, td.td_index});
    assign m_tuser = {td.kick_control_list, td.status, td.td_valid};
    assign m_tlast = td.last;

    `USB_TDS_ASSERT_IMP(a_pop_not_empty, q_pop, !q_empty)
    `USB_TDS_ASSERT_IMP(a_nondesc_clean, m_tvalid && !m_tuser[0], m_tlast && m_tdata == '0 && !m_tuser[2])
    `USB_TDS_ASSERT_IMP(a_desc_status_ok, m_tvalid && m_tuser[0], !m_tuser[1])
    `USB_TDS_ASSERT_NXT(a_cfg_write, cfg_valid, mpl_reg == $past(cfg_data))

endmodule
